// ----- design/tpq_pkg.sv -----
// Package for the timed packet queue: sizes, codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package tpq_pkg;
   localparam int QueueDepth = 32;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int FifoDepth = 2;

   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_DEST = 2'd2,
      MODE_FIND = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      EV_ACCEPT   = 3'd0,
      EV_FULL     = 3'd1,
      EV_TIMEOUT  = 3'd2,
      EV_DELIVER  = 3'd3,
      EV_NONE     = 3'd4,
      EV_FOUND    = 3'd5,
      EV_NOTFOUND = 3'd6
   } event_type;

   localparam logic CSR_HOLD = 1'b0;
   localparam logic CSR_MAX  = 1'b1;

   // One classified command handed from front to back.
   typedef struct packed {
      mode_type    mode;
      logic [31:0] now;
      logic [15:0] handle;
      logic [31:0] dest;
      logic [31:0] expiry;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PURGE,
      ST_SEARCH,
      ST_SHIFT,
      ST_EMIT
   } state_type;
endpackage

// ----- design/tpq_front.sv -----
// Front end: accepts request words, stamps expiry, queues commands.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_front import tpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now,
   input  logic [15:0] req_packet_handle,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] hold_time,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);
   cmd_type     fifo_ff [FifoDepth];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [32:0] sum;
   cmd_type     new_cmd;
   logic        push, pop;

   // Stamp saturating expiry
   always_comb begin
      sum = {1'b0, req_now} + {1'b0, hold_time};
      new_cmd.mode   = mode_type'(req_mode);
      new_cmd.now    = req_now;
      new_cmd.handle = req_packet_handle;
      new_cmd.dest   = req_dest_addr;
      new_cmd.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end

   assign req_stall = (cnt_ff == 2'(FifoDepth));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = fifo_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (push) fifo_ff[wp_ff] <= new_cmd;
   end
endmodule

// ----- design/tpq_back.sv -----
// Back end: entry store, purge/search/shift sequencer, result register.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_back import tpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   input  logic [5:0]  max_entries,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_handle_out,
   output logic        rsp_last
);
   logic [15:0] hnd_ff  [QueueDepth];
   logic [31:0] dst_ff  [QueueDepth];
   logic [31:0] exp_ff  [QueueDepth];

   state_type   st_ff, st_in;
   cmd_type     c_ff;
   logic [CntW-1:0] count_ff, count_in, pos_ff, pos_in;
   logic        fin_ff, fin_in;         // shift ends the item, else go back to purge
   logic        ov_ff, ov_in;
   logic [2:0]  oev_ff, oev_in;
   logic [15:0] oh_ff, oh_in;
   logic        ol_ff, ol_in;
   logic [CntW-1:0] lim;
   logic        wr_tail, do_shift;
   logic        out_free;

   assign out_free = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_event_res = oev_ff;
   assign rsp_handle_out = oh_ff;
   assign rsp_last = ol_ff;

   // Clamp the entry limit
   always_comb begin
      if (max_entries == 6'd0) lim = CntW'(1);
      else if (max_entries > 6'(QueueDepth)) lim = CntW'(QueueDepth);
      else lim = CntW'(max_entries);
   end

   // Sequence one command
   always_comb begin
      st_in = st_ff; count_in = count_ff; pos_in = pos_ff;
      fin_in = fin_ff;
      ov_in = ov_ff && rsp_stall; oev_in = oev_ff; oh_in = oh_ff; ol_in = ol_ff;
      cmd_take = 1'b0; wr_tail = 1'b0; do_shift = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1; pos_in = '0;
               st_in = (cmd.mode == MODE_FIND) ? ST_SEARCH : ST_PURGE;
            end
         end
         ST_PURGE: begin
            if (out_free) begin
               if (c_ff.mode == MODE_ENQ) begin
                  if (count_ff >= lim) begin
                     ov_in = 1'b1; ol_in = 1'b0; oh_in = hnd_ff[0];
                     oev_in = (exp_ff[0] > c_ff.now) ? EV_FULL : EV_TIMEOUT;
                     pos_in = '0; fin_in = 1'b0; st_in = ST_SHIFT;
                  end else begin
                     wr_tail = 1'b1; count_in = count_ff + 1'b1;
                     ov_in = 1'b1; ol_in = 1'b1; oev_in = EV_ACCEPT; oh_in = '0;
                     st_in = ST_IDLE;
                  end
               end else if (count_ff != '0 && exp_ff[0] < c_ff.now) begin
                  ov_in = 1'b1; ol_in = 1'b0; oev_in = EV_TIMEOUT; oh_in = hnd_ff[0];
                  pos_in = '0; fin_in = 1'b0; st_in = ST_SHIFT;
               end else begin
                  pos_in = '0; st_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // one entry per cycle
            if (pos_ff >= count_ff) begin
               st_in = ST_EMIT;
            end else if (c_ff.mode == MODE_DEQ ||
                         dst_ff[pos_ff[IdxW-1:0]] == c_ff.dest) begin
               st_in = ST_EMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1; ol_in = 1'b1; oh_in = '0;
               if (pos_ff >= count_ff) begin
                  oev_in = (c_ff.mode == MODE_FIND) ? EV_NOTFOUND : EV_NONE;
                  st_in = ST_IDLE;
               end else if (c_ff.mode == MODE_FIND) begin
                  oev_in = EV_FOUND; st_in = ST_IDLE;
               end else begin
                  oev_in = EV_DELIVER; oh_in = hnd_ff[pos_ff[IdxW-1:0]];
                  fin_in = 1'b1; st_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // close the gap one entry per cycle
            if (pos_ff + 1'b1 < count_ff) begin
               do_shift = 1'b1; pos_in = pos_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               st_in = fin_ff ? ST_IDLE : ST_PURGE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; count_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; count_ff <= count_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in; fin_ff <= fin_in;
      oev_ff <= oev_in; oh_ff <= oh_in; ol_ff <= ol_in;
      if (cmd_take) c_ff <= cmd;
   end

   // Entry store
   always_ff @(posedge clock) begin
      if (wr_tail) begin
         hnd_ff[count_ff[IdxW-1:0]] <= c_ff.handle;
         dst_ff[count_ff[IdxW-1:0]] <= c_ff.dest;
         exp_ff[count_ff[IdxW-1:0]] <= c_ff.expiry;
      end else if (do_shift) begin
         hnd_ff[pos_ff[IdxW-1:0]] <= hnd_ff[pos_in[IdxW-1:0]];
         dst_ff[pos_ff[IdxW-1:0]] <= dst_ff[pos_in[IdxW-1:0]];
         exp_ff[pos_ff[IdxW-1:0]] <= exp_ff[pos_in[IdxW-1:0]];
      end
   end
endmodule

// ----- design/timed_packet_queue_keyed_removal.sv -----
// Timed packet queue with keyed removal.
// Request words (req_) carry mode, now, handle and destination; the queue
// answers with one or more result words (rsp_), the final one marked by
// rsp_last. Mode enqueue drops oldest entries while at the limit, then
// accepts; dequeue modes purge expired head entries, then deliver the head
// or the oldest entry with a matching destination; find reports presence.
// A two-word command queue parts the front from the sequencer, so requests
// are taken while the sequencer works or a result waits on rsp_stall.
// An enqueue that drops nothing passes the command queue, is taken in
// ST_IDLE and registers its result in ST_PURGE. Each dropped or purged
// entry is reported from ST_PURGE, then ST_SHIFT moves the entries behind
// it down; a search visits one entry per cycle in ST_SEARCH and ST_EMIT
// writes the final word; a delivery closes the gap in ST_SHIFT before the
// next command starts. The sequencer handles one item at a time.
// csr_ index 0 writes hold_time, index 1 max_entries; always ready.
// Reset (synchronous) empties the queue and restores hold_time 30000 and
// max_entries 32. A stalled result holds; the sequencer waits to write the next.
// Depends on tpq_pkg, tpq_front, tpq_back.
`timescale 1ns / 1ps
module timed_packet_queue_keyed_removal import tpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now,
   input  logic [15:0] req_packet_handle,
   input  logic [31:0] req_dest_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_handle_out,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] hold_ff;
   logic [5:0]  max_ff;
   logic        cmd_valid, cmd_take;
   cmd_type     cmd;

   assign csr_ready = 1'b1;

   // Write configuration words
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 32'd30000; max_ff <= 6'd32;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HOLD: hold_ff <= csr_data;
            CSR_MAX:  max_ff <= csr_data[5:0];
            default:  ;
         endcase
      end
   end

   tpq_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_now,
      .req_packet_handle, .req_dest_addr, .hold_time(hold_ff),
      .cmd_valid, .cmd_take, .cmd
   );

   tpq_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .max_entries(max_ff),
      .rsp_valid, .rsp_stall, .rsp_event_res, .rsp_handle_out, .rsp_last
   );
endmodule

// ----- design/tpq_checker.sv -----
// Port-level checker for the timed packet queue, bound to the top level.
// Depends on tpq_pkg.
`timescale 1ns / 1ps
module tpq_checker import tpq_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [15:0] rsp_handle_out,
   input logic        rsp_last
);
   // Result codes stay in range
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EV_NOTFOUND) else $error("bad code");
   // Accept, none and find words carry no handle
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_ACCEPT || rsp_event_res == EV_NONE ||
      rsp_event_res == EV_FOUND || rsp_event_res == EV_NOTFOUND)
      |-> rsp_handle_out == '0) else $error("handle not zero");
   // Closing words end an item, drops never do
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_event_res != EV_FULL &&
      rsp_event_res != EV_TIMEOUT))) else $error("last mismatch");
   // Stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled word changed");
endmodule

bind timed_packet_queue_keyed_removal tpq_checker u_tpq_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_event_res, .rsp_handle_out,
   .rsp_last
);
